/* rtl/cgm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgm_pkg: shared types and codes of the collision group matrix
// Action codes, stream payload widths, register map and the update command
// that the top level broadcasts to every table cell.
// ----------------------------------------------------------------------------
package cgm_pkg;

	// action codes carried in the low bits of the input item
	localparam logic [2:0] ACT_REGISTER    = 3'd0;
	localparam logic [2:0] ACT_INDEX_OF    = 3'd1;
	localparam logic [2:0] ACT_NAME_OF     = 3'd2;
	localparam logic [2:0] ACT_SET_PAIR    = 3'd3;
	localparam logic [2:0] ACT_QUERY_PAIR  = 3'd4;
	localparam logic [2:0] ACT_MASK_OF     = 3'd5;
	localparam logic [2:0] ACT_RESET_TABLE = 3'd6;

	// packed payload widths, padded to whole bytes
	localparam int IN_BITS  = 80;
	localparam int OUT_BITS = 80;

	// register index (word address) of the default group key
	localparam logic REG_DEFAULT_KEY = 1'b0;

	// table update, already qualified by the commit of an item
	typedef struct packed {
		logic append;    // write the new key into the first free cell
		logic pair_wr;   // write the pair bit in the rows of both groups
		logic pair_val;  // value written for the pair
		logic clear;     // restore the default-only table
	} cgm_upd_t;

endpackage

/* rtl/cgm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgm_cell: one entry of the group table
// Holds one group key and its collide-with row, compares both search keys
// and adds its readout to the chain coming from the previous cell.
// ----------------------------------------------------------------------------
module cgm_cell #(
	parameter int LAYERS = 32,
	parameter int KW     = 32,
	parameter int IDX    = 0,
	parameter int CW     = $clog2(LAYERS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cgm_pkg::cgm_upd_t     upd,
	input  logic [CW-1:0]         used,
	input  logic [KW-1:0]         k1,
	input  logic [KW-1:0]         k2,
	input  logic [KW-1:0]         wkey,
	input  logic [KW-1:0]         dkey,
	input  logic [7:0]            gi,
	input  logic                  sel_a,
	input  logic                  sel_b,
	input  logic [LAYERS-1:0]     oh_a,
	input  logic [LAYERS-1:0]     oh_b,
	output logic                  hit1,
	output logic                  hit2,
	input  logic [KW-1:0]         name_in,
	output logic [KW-1:0]         name_out,
	input  logic [LAYERS-1:0]     rowg_in,
	output logic [LAYERS-1:0]     rowg_out,
	input  logic [LAYERS-1:0]     rowa_in,
	output logic [LAYERS-1:0]     rowa_out,
	input  logic                  gsel_in,
	output logic                  gsel_out
);
	import cgm_pkg::*;

	logic [KW-1:0]     my_key;
	logic [LAYERS-1:0] row_q;
	logic [LAYERS-1:0] pair_mask;
	logic [LAYERS-1:0] row_pair;
	logic              live;
	logic              at_end;
	logic              gsel;

	assign live   = CW'(IDX) < used;
	assign at_end = CW'(IDX) == used;
	assign gsel   = live && (gi == 8'(IDX));
	assign hit1   = live && (k1 == my_key);
	assign hit2   = live && (k2 == my_key);

	// as first group take the partner's bit, as second the first's
	assign pair_mask = ({LAYERS{sel_a}} & oh_b) | ({LAYERS{sel_b}} & oh_a);
	assign row_pair  = upd.pair_val ? (row_q | pair_mask) : (row_q & ~pair_mask);

	generate
		if (IDX == 0) begin : g_default
			// default group: key follows the register, row survives reset as all ones
			assign my_key = dkey;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					row_q <= '1;
				end else if (upd.clear) begin
					row_q <= '1;
				end else if (upd.pair_wr) begin
					row_q <= row_pair;
				end
			end
		end else begin : g_entry
			logic [KW-1:0] key_q;
			assign my_key = key_q;
			always_ff @(posedge clk) begin
				if (upd.append && at_end) begin
					key_q <= wkey;
					row_q <= '1;
				end else if (upd.pair_wr) begin
					row_q <= row_pair;
				end
			end
		end
	endgenerate

	// readout chain: each selected cell adds its entry
	assign name_out = name_in | (gsel ? my_key : '0);
	assign rowg_out = rowg_in | (gsel ? row_q : '0);
	assign rowa_out = rowa_in | (sel_a ? row_q : '0);
	assign gsel_out = gsel_in | gsel;

endmodule

/* rtl/collision_group_matrix_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collision_group_matrix_unit: collision group table with collide-with rows
// Registers group keys, looks them up, and keeps a symmetric matrix of which
// groups collide, in a row of LAYERS table cells.
// ----------------------------------------------------------------------------
// At the edge that accepts an item, every cell compares both keys of the
// item against its own entry in parallel and the hit vectors are held;
// then, once the output register is free or being emptied, the hits are
// resolved, the table cells are updated and the result is registered. The
// input side takes a new item only once the previous item has committed to
// the table, so a new item is never taken while another is in flight. A
// result waiting in the output register still lets the next item in; that
// item then holds in its stage, and the input stays closed, until the
// waiting result is taken. Entry 0 is the default group, whose key is the
// default_group_key register (reset value 1), so a register write renames
// it at once. Keys are compared in their low KEY_BITS bits, at most 32.
// After reset, or after a reset_table item, the table holds the default
// group alone with an all-ones row; no clearing pass is needed.
// ----------------------------------------------------------------------------
module collision_group_matrix_unit #(
	parameter int LAYERS   = 32,
	parameter int KEY_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// action[2:0], first_key[34:3], second_key[66:35], group_index[74:67],
	// set_to_collide[75], zero[79:76]
	input  logic [cgm_pkg::IN_BITS-1:0]   s_tdata,
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// ok[0], found_index[5:1], name_out[37:6], mask_out[69:38], collides[70],
	// group_count[76:71], zero[79:77]
	output logic [cgm_pkg::OUT_BITS-1:0]  m_tdata,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import cgm_pkg::*;

	localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int IW = $clog2(LAYERS);
	localparam int CW = $clog2(LAYERS + 1);

	// configuration register
	logic [31:0] dkey_q;

	// first stage: the accepted item and its hit vectors
	logic              busy_q;
	logic [2:0]        act_s1;
	logic [KW-1:0]     k1_s1;
	logic [7:0]        gi_s1;
	logic              on_s1;
	logic [LAYERS-1:0] m1_s1;
	logic [LAYERS-1:0] m2_s1;

	// table occupancy
	logic [CW-1:0] used_q;
	logic [CW-1:0] used_nxt;

	// output register
	logic                m_valid_q;
	logic [OUT_BITS-1:0] m_data_q;

	// cell wiring
	logic [KW-1:0]     k1_in;
	logic [KW-1:0]     k2_in;
	logic [LAYERS-1:0] hit1;
	logic [LAYERS-1:0] hit2;
	logic [LAYERS-1:0] r1;
	logic [LAYERS-1:0] r2;
	logic [KW-1:0]     name_ch [LAYERS+1];
	logic [LAYERS-1:0] rowg_ch [LAYERS+1];
	logic [LAYERS-1:0] rowa_ch [LAYERS+1];
	logic              gsel_ch [LAYERS+1];
	cgm_upd_t          upd;

	// result logic
	logic              s_fire;
	logic              commit;
	logic              found1;
	logic              found2;
	logic [IW-1:0]     idx1;
	logic              res_ok;
	logic [IW-1:0]     res_idx;
	logic [31:0]       res_name;
	logic [31:0]       res_mask;
	logic              res_col;
	logic [63:0]       idx_wide;
	logic [63:0]       cnt_wide;
	logic [63:0]       rowg_wide;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DEFAULT_KEY) ? dkey_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dkey_q <= 32'd1;
		end else if (psel && penable && pwrite && (paddr[2] == REG_DEFAULT_KEY)) begin
			dkey_q <= pwdata;
		end
	end

	// ---------------------------------------------------------------- handshake
	assign s_tready = !busy_q;
	assign s_fire   = s_tvalid && s_tready;
	// commit once the output register is free or being emptied
	assign commit   = busy_q && (!m_valid_q || m_tready);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// search keys straight off the bus, trimmed to the compared width
	assign k1_in = s_tdata[3 +: KW];
	assign k2_in = s_tdata[35 +: KW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (s_fire) begin
			busy_q <= 1'b1;
		end else if (commit) begin
			busy_q <= 1'b0;
		end
	end

	// hold the item and its hits for the commit cycle
	always_ff @(posedge clk) begin
		if (s_fire) begin
			act_s1 <= s_tdata[2:0];
			k1_s1  <= k1_in;
			gi_s1  <= s_tdata[74:67];
			on_s1  <= s_tdata[75];
			m1_s1  <= hit1;
			m2_s1  <= hit2;
		end
	end

	// ---------------------------------------------------------------- cells
	assign name_ch[0] = '0;
	assign rowg_ch[0] = '0;
	assign rowa_ch[0] = '0;
	assign gsel_ch[0] = 1'b0;

	generate
		for (genvar g = 0; g < LAYERS; g++) begin : g_cell
			cgm_cell #(
				.LAYERS (LAYERS),
				.KW     (KW),
				.IDX    (g),
				.CW     (CW)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.upd      (upd),
				.used     (used_q),
				.k1       (k1_in),
				.k2       (k2_in),
				.wkey     (k1_s1),
				.dkey     (dkey_q[KW-1:0]),
				.gi       (gi_s1),
				.sel_a    (r1[g]),
				.sel_b    (r2[g]),
				.oh_a     (r1),
				.oh_b     (r2),
				.hit1     (hit1[g]),
				.hit2     (hit2[g]),
				.name_in  (name_ch[g]),
				.name_out (name_ch[g+1]),
				.rowg_in  (rowg_ch[g]),
				.rowg_out (rowg_ch[g+1]),
				.rowa_in  (rowa_ch[g]),
				.rowa_out (rowa_ch[g+1]),
				.gsel_in  (gsel_ch[g]),
				.gsel_out (gsel_ch[g+1])
			);
		end
	endgenerate

	// ---------------------------------------------------------------- resolve
	// Only the default entry can share a key with another live entry (after
	// the default key is renamed), and the lowest index wins: prefer entry 0.
	assign r1     = m1_s1[0] ? LAYERS'(1) : m1_s1;
	assign r2     = m2_s1[0] ? LAYERS'(1) : m2_s1;
	assign found1 = |m1_s1;
	assign found2 = |m2_s1;

	always_comb begin
		idx1 = '0;
		for (int i = 0; i < LAYERS; i++) begin
			if (r1[i]) begin
				idx1 = idx1 | IW'(i);
			end
		end
	end

	assign rowg_wide = 64'(rowg_ch[LAYERS]);

	// ---------------------------------------------------------------- result
	always_comb begin
		upd      = '0;
		used_nxt = used_q;
		res_ok   = 1'b0;
		res_idx  = '0;
		res_name = 32'd0;
		res_mask = 32'd0;
		res_col  = 1'b0;
		case (act_s1)
			ACT_REGISTER: begin
				if (found1) begin
					res_ok  = 1'b1;
					res_idx = idx1;
				end else if (used_q < CW'(LAYERS)) begin
					upd.append = commit;
					used_nxt   = used_q + CW'(1);
					res_ok     = 1'b1;
					res_idx    = used_q[IW-1:0];
				end
			end
			ACT_INDEX_OF: begin
				if (found1) begin
					res_ok  = 1'b1;
					res_idx = idx1;
				end
			end
			ACT_NAME_OF: begin
				res_ok   = gsel_ch[LAYERS];
				res_name = 32'(name_ch[LAYERS]);
			end
			ACT_SET_PAIR: begin
				if (found1 && found2) begin
					upd.pair_wr  = commit;
					upd.pair_val = on_s1;
					res_ok       = 1'b1;
				end
			end
			ACT_QUERY_PAIR: begin
				if (found1 && found2) begin
					res_ok  = 1'b1;
					res_col = |(rowa_ch[LAYERS] & r2);
				end
			end
			ACT_MASK_OF: begin
				res_ok   = gsel_ch[LAYERS];
				res_mask = gsel_ch[LAYERS] ? rowg_wide[31:0] : 32'hFFFF_FFFF;
			end
			ACT_RESET_TABLE: begin
				upd.clear = commit;
				used_nxt  = CW'(1);
				res_ok    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign idx_wide = 64'(res_idx);
	assign cnt_wide = 64'(used_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= CW'(1);
			m_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				used_q    <= used_nxt;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// result payload, packed as listed at the port
	always_ff @(posedge clk) begin
		if (commit) begin
			m_data_q <= {3'd0, cnt_wide[5:0], res_col, res_mask, res_name,
				idx_wide[4:0], res_ok};
		end
	end

endmodule

/* rtl/cgm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgm_checker: port-level checks of the collision group matrix
// Watches the stream ports of the top level; attached by a bind statement.
// ----------------------------------------------------------------------------
module cgm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [cgm_pkg::OUT_BITS-1:0]  m_tdata
);
	import cgm_pkg::*;

	// the input closes until the accepted item has committed
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in flight");

	// after an acceptance the output comes to hold a result: this item's,
	// or an older one held by a stall
	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> ##2 m_tvalid)
		else $error("result missing after an accepted item");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	// a refused or unknown item reports index zero and no collision
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[5:1] == 5'd0 && !m_tdata[70]))
		else $error("index or collision set on a refused item");

endmodule

bind collision_group_matrix_unit cgm_checker u_cgm_checker (.*);
